// ===== hw/rtl/baro_pressure_temp_compensation_unit_defines.svh =====
// Assertion macros for the barometric compensation unit.
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_UNIT_DEFINES_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_UNIT_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk, off while rst is high.
`define BARO_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("baro assertion failed");
// Next-cycle implication.
`define BARO_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("baro assertion failed");
`else
`define BARO_ASSERT_IMPLY(label, ante, cons)
`define BARO_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hw/rtl/baro_pkg.sv =====
// Shared types, widths and constants for the barometric compensation unit.
package baro_pkg;

  localparam int RAW_W     = 24;
  localparam int COEF_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int DT_W      = 25;              // d2 - c5*256
  localparam int MUL_W     = DT_W + COEF_W + 1; // dt times one coefficient
  localparam int DTSQ_W    = 2 * DT_W - 2;
  localparam int A_W       = 18;              // temp - 2000
  localparam int B_W       = 19;              // temp + 1500
  localparam int TEMP_W    = 19;
  localparam int T2_W      = 17;
  localparam int OFF_W     = 36;
  localparam int SENS_W    = 35;
  localparam int SQ_W      = 34;
  localparam int CORR_W    = 38;              // off2 / sens2
  localparam int WIDE_W    = 40;              // corrected off / sens
  localparam int TEMPF_W   = 20;
  localparam int MAG_W     = 20;
  localparam int PLO_W     = RAW_W + 20;
  localparam int PHI_W     = RAW_W + 21;
  localparam int PROD_W    = 64;
  localparam int DIFF_W    = 44;
  localparam int QUOT_W    = 14;
  localparam int PRESS_W   = 18;
  localparam int DEG_W     = 8;

  localparam logic signed [TEMP_W-1:0] TEMP_REF = 19'sd2000;
  localparam logic signed [B_W-1:0]    B_SHIFT  = 19'sd3500;
  localparam logic signed [A_W-1:0]    A_LOW    = -18'sd3500;

  // x / 100 == (x * 671089) >> 26 for x below 2^20
  localparam logic [MAG_W-1:0] DIV100_RECIP = 20'd671089;
  localparam int               DIV100_SHIFT = 26;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENS        = 3'd0,
    REG_OFFSET      = 3'd1,
    REG_SENS_TEMP   = 3'd2,
    REG_OFFSET_TEMP = 3'd3,
    REG_REF_TEMP    = 3'd4,
    REG_TEMP_SLOPE  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [COEF_W-1:0] sens;
    logic [COEF_W-1:0] offset;
    logic [COEF_W-1:0] sens_temp;
    logic [COEF_W-1:0] offset_temp;
    logic [COEF_W-1:0] ref_temp;
    logic [COEF_W-1:0] temp_slope;
  } coeffs_t;

  // One reading after first-order compensation, waiting for the back end.
  typedef struct packed {
    logic [RAW_W-1:0]         d1;
    logic signed [TEMP_W-1:0] temp;
    logic [T2_W-1:0]          t2;
    logic signed [OFF_W-1:0]  off;
    logic signed [SENS_W-1:0] sens;
    logic [SQ_W-1:0]          sq;
    logic [SQ_W-1:0]          sq2;
    logic                     below;  // under 20.00 C
    logic                     low;    // under -15.00 C
  } item_t;

endpackage

// ===== hw/rtl/baro_pressure_temp_compensation_unit.sv =====
// Top level of the barometric pressure and temperature compensation unit.
//
// Input channel: in_valid/in_ready carry one beat of raw_pressure (D1) and
// raw_temperature (D2), 24 bits each. Output channel: out_valid/out_ready
// carry temperature_deg (whole degrees C, signed, saturated) and
// pressure_pa (pascals, clamped to 0..262143). One result beat per input.
// Calibration words C1..C6 are written through cfg_wr_en/cfg_index/cfg_data
// (indexes 0..5, others ignored); write them only while the unit is idle.
// Throughput: one beat per cycle while out_ready is high and the queue is
// not full. Path from input beat to output valid: 4 front stages (dt,
// products, first-order terms, squares), the queue, 5 back stages
// (corrections, corrected off/sens, split D1*SENS product and /100 product, product sum, clamp).
// The front and back pipes are joined by a 4-entry queue: when out_ready
// is low the back end holds, the queue fills, and only then in_ready drops.
// Reset clears all valids, the queue and the calibration words (to zero).
`include "baro_pressure_temp_compensation_unit_defines.svh"
module baro_pressure_temp_compensation_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [baro_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [baro_pkg::COEF_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [baro_pkg::RAW_W-1:0]          raw_pressure,
  input  logic [baro_pkg::RAW_W-1:0]          raw_temperature,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [baro_pkg::DEG_W-1:0]   temperature_deg,
  output logic [baro_pkg::PRESS_W-1:0]        pressure_pa
);
  import baro_pkg::*;

  coeffs_t coeffs;
  item_t   push_item, head_item;
  logic    q_push, q_pop, q_full, q_empty;

  // calibration words, plain write port
  always_ff @(posedge clk) begin
    if (rst) begin
      coeffs <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_SENS:        coeffs.sens        <= cfg_data;
        REG_OFFSET:      coeffs.offset      <= cfg_data;
        REG_SENS_TEMP:   coeffs.sens_temp   <= cfg_data;
        REG_OFFSET_TEMP: coeffs.offset_temp <= cfg_data;
        REG_REF_TEMP:    coeffs.ref_temp    <= cfg_data;
        REG_TEMP_SLOPE:  coeffs.temp_slope  <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: accepts beats, dt, first-order temp/off/sens, classes, squares
  baro_front u_front (
    .clk             (clk),
    .rst             (rst),
    .coeffs          (coeffs),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .raw_pressure    (raw_pressure),
    .raw_temperature (raw_temperature),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_item          (push_item)
  );

  // decoupling queue, lets the back end stall without stopping the front
  baro_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .head_item (head_item),
    .empty     (q_empty)
  );

  // back: second-order terms, pressure product, /100, clamps, output register
  baro_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_item          (head_item),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .temperature_deg (temperature_deg),
    .pressure_pa     (pressure_pa)
  );

  // queue never overflows or underflows
  `BARO_ASSERT_IMPLY(a_no_push_when_full, q_push, !q_full)
  `BARO_ASSERT_IMPLY(a_no_pop_when_empty, q_pop, !q_empty)
  // input back-pressure only comes from a full queue
  `BARO_ASSERT_IMPLY(a_stall_only_on_full, !in_ready, q_full)
  // a stalled output beat freezes the back end
  `BARO_ASSERT_IMPLY(a_hold_back_on_stall, out_valid && !out_ready, !q_pop)
  // a beat written alone leaves the queue occupied
  `BARO_ASSERT_NEXT(a_push_fills, q_push && !q_pop, !q_empty)

endmodule

// ===== hw/rtl/baro_front.sv =====
// Front end: takes reading beats, first-order compensation and range classing.
module baro_front (
  input  logic                          clk,
  input  logic                          rst,
  input  baro_pkg::coeffs_t             coeffs,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [baro_pkg::RAW_W-1:0]    raw_pressure,
  input  logic [baro_pkg::RAW_W-1:0]    raw_temperature,
  input  logic                          q_full,
  output logic                          q_push,
  output baro_pkg::item_t               q_item
);
  import baro_pkg::*;

  logic en;
  logic s1_valid, s2_valid, s3_valid, s4_valid;

  logic signed [DT_W-1:0]   dt_next;
  logic [RAW_W-1:0]         s1_d1;
  logic signed [DT_W-1:0]   s1_dt;

  logic signed [MUL_W-1:0]    dtc6_next, c4dt_next, c3dt_next;
  logic signed [2*DT_W-1:0]   dtsq_next;
  logic [RAW_W-1:0]           s2_d1;
  logic signed [MUL_W-1:0]    s2_dtc6, s2_c4dt, s2_c3dt;
  logic [DTSQ_W-1:0]          s2_dtsq;

  logic signed [A_W-1:0]    a_next;
  logic signed [B_W-1:0]    b_next;
  logic signed [TEMP_W-1:0] temp_next;
  logic signed [OFF_W-1:0]  off_next;
  logic signed [SENS_W-1:0] sens_next;
  logic [RAW_W-1:0]         s3_d1;
  logic signed [A_W-1:0]    s3_a;
  logic signed [B_W-1:0]    s3_b;
  logic signed [TEMP_W-1:0] s3_temp;
  logic [T2_W-1:0]          s3_t2;
  logic signed [OFF_W-1:0]  s3_off;
  logic signed [SENS_W-1:0] s3_sens;
  logic                     s3_below, s3_low;

  logic signed [2*A_W-1:0]  sq_next;
  logic signed [2*B_W-1:0]  sq2_next;
  item_t                    s4_item;

  // whole pipe holds only when the queue is full and the last stage is loaded
  assign en       = !(q_full && s4_valid);
  assign in_ready = en;
  assign q_push   = en && s4_valid;
  assign q_item   = s4_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  // stage 1: dt
  assign dt_next = $signed({1'b0, raw_temperature}) - $signed({1'b0, coeffs.ref_temp, 8'd0});

  // stage 2: products with dt
  assign dtc6_next = s1_dt * $signed({1'b0, coeffs.temp_slope});
  assign c4dt_next = s1_dt * $signed({1'b0, coeffs.offset_temp});
  assign c3dt_next = s1_dt * $signed({1'b0, coeffs.sens_temp});
  assign dtsq_next = s1_dt * s1_dt;

  // stage 3: first-order terms; shifts floor by taking upper bits
  assign a_next    = s2_dtc6[A_W+22:23];
  assign temp_next = TEMP_REF + {a_next[A_W-1], a_next};
  assign b_next    = {a_next[A_W-1], a_next} + B_SHIFT;
  assign off_next  = $signed({4'd0, coeffs.offset, 16'd0})
                   + {s2_c4dt[MUL_W-1], s2_c4dt[MUL_W-1:7]};
  assign sens_next = $signed({4'd0, coeffs.sens, 15'd0})
                   + {s2_c3dt[MUL_W-1], s2_c3dt[MUL_W-1:8]};

  // stage 4: squares for the second-order terms (only used when in range)
  assign sq_next  = s3_a * s3_a;
  assign sq2_next = s3_b * s3_b;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_d1   <= raw_pressure;
      s1_dt   <= dt_next;

      s2_d1   <= s1_d1;
      s2_dtc6 <= dtc6_next;
      s2_c4dt <= c4dt_next;
      s2_c3dt <= c3dt_next;
      s2_dtsq <= dtsq_next[DTSQ_W-1:0];

      s3_d1    <= s2_d1;
      s3_a     <= a_next;
      s3_b     <= b_next;
      s3_temp  <= temp_next;
      s3_t2    <= s2_dtsq[DTSQ_W-1:31];
      s3_off   <= off_next;
      s3_sens  <= sens_next;
      s3_below <= a_next[A_W-1];
      s3_low   <= (a_next < A_LOW);

      s4_item.d1    <= s3_d1;
      s4_item.temp  <= s3_temp;
      s4_item.t2    <= s3_t2;
      s4_item.off   <= s3_off;
      s4_item.sens  <= s3_sens;
      s4_item.sq    <= sq_next[SQ_W-1:0];
      s4_item.sq2   <= sq2_next[SQ_W-1:0];
      s4_item.below <= s3_below;
      s4_item.low   <= s3_low;
    end
  end

endmodule

// ===== hw/rtl/baro_queue.sv =====
// Short first-word-fall-through queue between front and back ends.
module baro_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  baro_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output baro_pkg::item_t head_item,
  output logic            empty
);
  import baro_pkg::*;

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty     = (count == '0);
  assign head_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

endmodule

// ===== hw/rtl/baro_back.sv =====
// Back end: second-order corrections, pressure product, /100 and saturation.
module baro_back (
  input  logic                              clk,
  input  logic                              rst,
  input  baro_pkg::item_t                   q_item,
  input  logic                              q_empty,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [baro_pkg::DEG_W-1:0] temperature_deg,
  output logic [baro_pkg::PRESS_W-1:0]      pressure_pa
);
  import baro_pkg::*;

  logic en;
  logic b0_valid, b1_valid, b2_valid, b3_valid;

  // stage 0
  logic [CORR_W-2:0]         five_sq, seven_sq2;
  logic [CORR_W-1:0]         eleven_sq2;
  logic [CORR_W-1:0]         off2_next, sens2_next;
  logic signed [TEMPF_W-1:0] tempf_next;
  logic [RAW_W-1:0]          b0_d1;
  logic signed [OFF_W-1:0]   b0_off;
  logic signed [SENS_W-1:0]  b0_sens;
  logic [CORR_W-1:0]         b0_off2, b0_sens2;
  logic signed [TEMPF_W-1:0] b0_temp;

  // stage 1
  logic [RAW_W-1:0]         b1_d1;
  logic signed [WIDE_W-1:0] b1_off, b1_sens;
  logic                     b1_neg;
  logic [MAG_W-1:0]         b1_mag;

  // stage 2
  logic [PLO_W-1:0]         b2_plo;
  logic signed [PHI_W-1:0]  b2_phi;
  logic [MAG_W*2-1:0]       b2_quot;
  logic signed [WIDE_W-1:0] b2_off;
  logic                     b2_neg;

  // stage 3
  logic signed [PROD_W-1:0] b3_prod;
  logic signed [WIDE_W-1:0] b3_off;
  logic                     b3_neg;
  logic [QUOT_W-1:0]        b3_mag;

  // output stage
  logic signed [DIFF_W-1:0] diff;
  logic [PRESS_W-1:0]       press_next;
  logic signed [DEG_W-1:0]  deg_next;

  assign en    = !out_valid || out_ready;
  assign q_pop = en && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      b0_valid  <= 1'b0;
      b1_valid  <= 1'b0;
      b2_valid  <= 1'b0;
      b3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      b0_valid  <= q_pop;
      b1_valid  <= b0_valid;
      b2_valid  <= b1_valid;
      b3_valid  <= b2_valid;
      out_valid <= b3_valid;
    end
  end

  // constant multiples by shift and add
  assign five_sq    = {1'b0, q_item.sq, 2'd0} + {3'd0, q_item.sq};
  assign seven_sq2  = {q_item.sq2, 3'd0} - {3'd0, q_item.sq2};
  assign eleven_sq2 = {1'b0, q_item.sq2, 3'd0} + {3'd0, q_item.sq2, 1'b0}
                    + {4'd0, q_item.sq2};

  always_comb begin
    off2_next  = '0;
    sens2_next = '0;
    tempf_next = {q_item.temp[TEMP_W-1], q_item.temp};
    if (q_item.below) begin
      off2_next  = {2'd0, five_sq[CORR_W-2:1]};
      sens2_next = {3'd0, five_sq[CORR_W-2:2]};
      tempf_next = {q_item.temp[TEMP_W-1], q_item.temp} - $signed({3'd0, q_item.t2});
      if (q_item.low) begin
        off2_next  = off2_next + {1'b0, seven_sq2};
        sens2_next = sens2_next + {1'b0, eleven_sq2[CORR_W-1:1]};
      end
    end
  end

  always_comb begin
    diff = {b3_prod[PROD_W-1], b3_prod[PROD_W-1:21]}
         - {{(DIFF_W-WIDE_W){b3_off[WIDE_W-1]}}, b3_off};
    // floor by 2^15 then clamp to the pascal range
    if (diff[DIFF_W-1])                 press_next = '0;
    else if (|diff[DIFF_W-2:PRESS_W+15]) press_next = '1;
    else                                 press_next = diff[PRESS_W+14:15];

    if (!b3_neg) begin
      deg_next = (b3_mag > QUOT_W'(127)) ? 8'sd127 : $signed(b3_mag[DEG_W-1:0]);
    end else begin
      deg_next = (b3_mag > QUOT_W'(128)) ? -8'sd128
                                         : $signed(~b3_mag[DEG_W-1:0] + 8'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b0_d1    <= q_item.d1;
      b0_off   <= q_item.off;
      b0_sens  <= q_item.sens;
      b0_off2  <= off2_next;
      b0_sens2 <= sens2_next;
      b0_temp  <= tempf_next;

      b1_d1   <= b0_d1;
      b1_off  <= {{(WIDE_W-OFF_W){b0_off[OFF_W-1]}}, b0_off} - $signed({2'd0, b0_off2});
      b1_sens <= {{(WIDE_W-SENS_W){b0_sens[SENS_W-1]}}, b0_sens}
               - $signed({2'd0, b0_sens2});
      b1_neg  <= b0_temp[TEMPF_W-1];
      b1_mag  <= b0_temp[TEMPF_W-1] ? MAG_W'(-b0_temp) : MAG_W'(b0_temp);

      // split d1 * sens into two partial products
      b2_plo  <= b1_d1 * b1_sens[19:0];
      b2_phi  <= $signed({1'b0, b1_d1}) * $signed(b1_sens[WIDE_W-1:20]);
      b2_quot <= b1_mag * DIV100_RECIP;
      b2_off  <= b1_off;
      b2_neg  <= b1_neg;

      b3_prod <= $signed({b2_phi[PROD_W-21:0], 20'd0}) + $signed({20'd0, b2_plo});
      b3_off  <= b2_off;
      b3_neg  <= b2_neg;
      b3_mag  <= b2_quot[DIV100_SHIFT+QUOT_W-1:DIV100_SHIFT];

      temperature_deg <= deg_next;
      pressure_pa     <= press_next;
    end
  end

endmodule
